[rtl/core/nmss_pkg.sv]
`timescale 1ns / 1ps
// Package: widths, codes, state type and saturation helpers for the neuron MAC.
package nmss_pkg;

  localparam int SRC_W   = 16;
  localparam int PROD_W  = 32;
  localparam int ACC_W   = 40;
  localparam int RES_W   = 32;
  localparam int KIND_W  = 2;
  localparam int DLEN_W  = 7;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;
  localparam int FRAC_W  = 24;
  localparam int DIV_STEPS = FRAC_W;
  localparam int CNT_W   = $clog2(DIV_STEPS);

  localparam logic [ACC_W-1:0] ONE_Q24 = ACC_W'(1) << FRAC_W;

  localparam logic ADDR_KIND = 1'b0;
  localparam logic ADDR_DLEN = 1'b1;

  localparam logic [KIND_W-1:0] KIND_SOFTSIGN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LINEAR   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELAYED  = 2'd2;

  typedef enum logic [5:0] {
    S_MAC  = 6'b000001,
    S_SUM  = 6'b000010,
    S_PREP = 6'b000100,
    S_DIV  = 6'b001000,
    S_READ = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
    logic signed [ACC_W-1:0] r;
    if (v[ACC_W] != v[ACC_W-1]) begin
      r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [RES_W-1:0] sat_res(input logic signed [ACC_W-1:0] v);
    logic signed [RES_W-1:0] r;
    if (v[ACC_W-1:RES_W-1] == '0 || v[ACC_W-1:RES_W-1] == '1) begin
      r = v[RES_W-1:0];
    end else begin
      r = v[ACC_W-1] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

[rtl/core/neuron_mac_softsign.sv]
`timescale 1ns / 1ps
// Top level: single perceptron neuron with link MAC and selectable activation.
// Links stream in at one request per cycle while in_ready is high, through a
// registered 16x16 product and a saturating 40-bit Q16.24 accumulator. The
// request marked last_link ends the evaluation and drops in_ready through S_SUM
// and then S_OUT (linear kind), S_READ and S_OUT (delayed kind, one read of the
// delay-line memory) or S_PREP, S_DIV and S_OUT (softsign kind, a setup state
// and a 24-step restoring divider producing one quotient bit per cycle);
// in_ready stays low longer while the previous result still waits in the
// output register. The delay line is a MAX_DELAY-entry synchronous memory; a
// fill count stands in for its cleared contents, so there is no clearing pass
// after reset or after a write of delay_length. A finished result waits in the
// output register while the next evaluation's links are taken.
module neuron_mac_softsign
  import nmss_pkg::*;
#(
  parameter int MAX_DELAY = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [SRC_W-1:0]  source_value,
  input  logic signed [SRC_W-1:0]  link_weight,
  input  logic                     last_link,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [RES_W-1:0]  result_value
);

  localparam int PTR_W = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int DLY_W = $clog2(MAX_DELAY + 1);
  localparam int CMP_W = (DLY_W > DLEN_W) ? DLY_W : DLEN_W;

  state_t state;

  logic [KIND_W-1:0] neuron_kind;
  logic [DLEN_W-1:0] delay_length;

  logic signed [PROD_W-1:0] prod;
  logic                     prod_valid;
  logic                     prod_last;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_sum;
  logic signed [ACC_W-1:0]  sum;
  logic signed [RES_W-1:0]  sum32;
  logic signed [RES_W-1:0]  res;

  logic [ACC_W-1:0]  div_rem;
  logic [ACC_W-1:0]  div_den;
  logic [ACC_W:0]    rem_sh;
  logic              rem_ge;
  logic [FRAC_W-1:0] div_q;
  logic [FRAC_W-1:0] q_next;
  logic              div_neg;
  logic [CNT_W-1:0]  div_cnt;
  logic [ACC_W-1:0]  mag;

  logic [RES_W-1:0] dmem [MAX_DELAY];
  logic [RES_W-1:0] rd_data;
  logic [PTR_W-1:0] ptr;
  logic [PTR_W-1:0] rd_idx;
  logic [DLY_W-1:0] fill;
  logic [CMP_W-1:0] dlen_ext;
  logic [DLY_W-1:0] dly;
  logic [DLY_W:0]   idx_wide;
  logic             cfg_we;
  logic             out_load;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    case (paddr[2])
      ADDR_KIND: prdata = DATA_W'(neuron_kind);
      ADDR_DLEN: prdata = DATA_W'(delay_length);
      default:   prdata = '0;
    endcase
  end

  assign in_ready = (state == S_MAC);
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  assign acc_sum = sat_acc((ACC_W+1)'(acc) + (ACC_W+1)'(prod));
  assign sum32   = sat_res(sum);
  assign mag     = sum[ACC_W-1] ? ACC_W'(-sum) : ACC_W'(sum);

  assign rem_sh  = {div_rem, 1'b0};
  assign rem_ge  = rem_sh >= {1'b0, div_den};
  assign q_next  = {div_q[FRAC_W-2:0], rem_ge};

  assign dlen_ext = CMP_W'(delay_length);
  assign dly      = (dlen_ext > CMP_W'(MAX_DELAY)) ? DLY_W'(MAX_DELAY) : DLY_W'(dlen_ext);
  assign idx_wide = ((DLY_W+1)'(ptr) >= (DLY_W+1)'(dly)) ?
                    (DLY_W+1)'(ptr) - (DLY_W+1)'(dly) :
                    (DLY_W+1)'(ptr) + (DLY_W+1)'(MAX_DELAY) - (DLY_W+1)'(dly);
  assign rd_idx   = idx_wide[PTR_W-1:0];

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      dmem[ptr] <= sum32;
    end
    rd_data <= dmem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      neuron_kind  <= KIND_SOFTSIGN;
      delay_length <= '0;
    end else if (cfg_we) begin
      case (paddr[2])
        ADDR_KIND: neuron_kind  <= pwdata[KIND_W-1:0];
        ADDR_DLEN: delay_length <= pwdata[DLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      prod      <= PROD_W'(source_value) * PROD_W'(link_weight);
      prod_last <= last_link;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_MAC;
      prod_valid <= 1'b0;
      acc        <= '0;
      out_valid  <= 1'b0;
      ptr        <= '0;
      fill       <= '0;
      div_cnt    <= '0;
    end else begin
      prod_valid <= in_valid && in_ready;
      if (prod_valid) begin
        acc <= prod_last ? '0 : acc_sum;
      end
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      if (cfg_we && paddr[2] == ADDR_DLEN) begin
        ptr  <= '0;
        fill <= '0;
      end
      case (state)
        S_MAC: begin
          if (in_valid && last_link) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          case (neuron_kind)
            KIND_SOFTSIGN: state <= S_PREP;
            KIND_DELAYED:  state <= S_READ;
            default:       state <= S_OUT;
          endcase
        end
        S_PREP: begin
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == CNT_W'(DIV_STEPS - 1)) begin
            state <= S_OUT;
          end
        end
        S_READ: begin
          ptr <= (ptr == PTR_W'(MAX_DELAY - 1)) ? '0 : ptr + 1'b1;
          if (fill != DLY_W'(MAX_DELAY)) begin
            fill <= fill + 1'b1;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_valid <= 1'b1;
            state     <= S_MAC;
          end
        end
        default: state <= S_MAC;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_SUM: begin
        sum <= acc_sum;
        res <= sat_res(acc_sum);
      end
      S_PREP: begin
        div_neg <= sum[ACC_W-1];
        div_rem <= mag;
        div_den <= ONE_Q24 + mag;
        div_q   <= '0;
      end
      S_DIV: begin
        div_rem <= rem_ge ? ACC_W'(rem_sh - {1'b0, div_den}) : rem_sh[ACC_W-1:0];
        div_q   <= q_next;
        if (div_cnt == CNT_W'(DIV_STEPS - 1)) begin
          res <= div_neg ? -RES_W'(q_next) : RES_W'(q_next);
        end
      end
      S_READ: begin
        if (dly == '0) begin
          res <= sum32;
        end else if (fill < dly) begin
          res <= '0;
        end else begin
          res <= rd_data;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      result_value <= res;
    end
  end

endmodule

[rtl/core/nmss_check.sv]
`timescale 1ns / 1ps
// Checker: port-level assertions for the neuron MAC, bound to the top level.
module nmss_check
  import nmss_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     psel,
  input logic [ADDR_W-1:0]        paddr,
  input logic [DATA_W-1:0]        prdata,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     last_link,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [RES_W-1:0]  result_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value))
    else $error("result changed or dropped while stalled");

  a_last_stops_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_link |=> !in_ready)
    else $error("input still ready right after a last link");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_kind_readback: assert property (@(posedge clk) disable iff (rst)
    psel && paddr[2] == ADDR_KIND |-> prdata[DATA_W-1:KIND_W] == '0)
    else $error("neuron kind readback wider than its field");

endmodule

bind neuron_mac_softsign nmss_check u_nmss_check (.*);

[bench/tb_neuron_mac_softsign.sv]
`timescale 1ns / 1ps
// Testbench for neuron_mac_softsign: directed and random link streams checked against a predictor.
module tb_neuron_mac_softsign;
  import nmss_pkg::*;

  localparam int               DELAY_DEPTH  = 64;
  localparam int               STALL_LIMIT  = 2000;
  localparam int               RANDOM_LINKS = 160;
  localparam int               SETTLE_CYCLES = 40;
  localparam logic [ADDR_W-1:0] REG_KIND = {ADDR_KIND, 2'b00};
  localparam logic [ADDR_W-1:0] REG_DLEN = {ADDR_DLEN, 2'b00};
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam logic signed [SRC_W-1:0] Q_MIN = 16'sh8000;
  localparam logic signed [SRC_W-1:0] Q_MAX = 16'sh7FFF;
  localparam logic signed [ACC_W-1:0] RES_HI = 40'sd2147483647;
  localparam logic signed [ACC_W-1:0] RES_LO = -40'sd2147483648;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ADDR_W-1:0]       paddr = '0;
  logic [DATA_W-1:0]       pwdata = '0;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [SRC_W-1:0] source_value = '0;
  logic signed [SRC_W-1:0] link_weight = '0;
  logic                    last_link = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [RES_W-1:0] result_value;

  neuron_mac_softsign dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .source_value(source_value), .link_weight(link_weight), .last_link(last_link),
    .out_valid(out_valid), .out_ready(out_ready), .result_value(result_value)
  );

  logic [KIND_W-1:0]       kind_q;
  logic [DLEN_W-1:0]       dlen_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [RES_W-1:0] delay_mem [DELAY_DEPTH];
  logic [5:0]              delay_ptr;
  logic signed [RES_W-1:0] pending_results [$];
  bit                      idle_en = 1'b1;
  int                      fail_count = 0;
  int                      links_sent = 0;
  int                      stall_left = 0;
  int                      quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic signed [RES_W-1:0] clamp32(input logic signed [ACC_W-1:0] v);
    if (v > RES_HI) return RES_HI[RES_W-1:0];
    if (v < RES_LO) return RES_LO[RES_W-1:0];
    return v[RES_W-1:0];
  endfunction

  function automatic logic signed [RES_W-1:0] softsign_q24(input logic signed [ACC_W-1:0] s);
    logic signed [63:0] s64;
    logic [63:0]        mag;
    logic [63:0]        quo;
    s64 = s;
    mag = (s64 < 0) ? -s64 : s64;
    quo = (mag << FRAC_W) / ((64'd1 << FRAC_W) + mag);
    return (s64 < 0) ? -quo[RES_W-1:0] : quo[RES_W-1:0];
  endfunction

  function automatic logic signed [RES_W-1:0] delay_tap(input logic signed [RES_W-1:0] now);
    logic [DLEN_W-1:0]       lag;
    logic signed [RES_W-1:0] r;
    lag = (dlen_q > DELAY_DEPTH) ? DLEN_W'(DELAY_DEPTH) : dlen_q;
    r = now;
    if (lag != 0) r = delay_mem[delay_ptr - lag[5:0]];
    delay_mem[delay_ptr] = now;
    delay_ptr = delay_ptr + 1'b1;
    return r;
  endfunction

  task automatic accumulate_link(input logic signed [SRC_W-1:0] v,
                                 input logic signed [SRC_W-1:0] w, input logic last);
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W:0]    sum;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [RES_W-1:0]  r;
    prod = v * w;
    sum = acc_q + prod;
    if (sum[ACC_W] != sum[ACC_W-1])
      acc_next = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    else
      acc_next = sum[ACC_W-1:0];
    if (!last) begin
      acc_q = acc_next;
    end else begin
      acc_q = '0;
      case (kind_q)
        KIND_SOFTSIGN: r = softsign_q24(acc_next);
        KIND_DELAYED:  r = delay_tap(clamp32(acc_next));
        default:       r = clamp32(acc_next);
      endcase
      pending_results = {pending_results, r};
    end
  endtask

  task automatic reset_predictor();
    kind_q = KIND_SOFTSIGN;
    dlen_q = '0;
    acc_q = '0;
    delay_ptr = '0;
    foreach (delay_mem[i]) delay_mem[i] = '0;
  endtask

  task automatic send_link(input logic signed [SRC_W-1:0] v,
                           input logic signed [SRC_W-1:0] w, input logic last);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    source_value <= v;
    link_weight  <= w;
    last_link    <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accumulate_link(v, w, last);
    links_sent++;
  endtask

  task automatic release_links();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic hold_for_results();
    release_links();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] expected;
    expected = '0;
    hold_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == REG_KIND) begin
      kind_q = data[KIND_W-1:0];
      expected = DATA_W'(kind_q);
    end else if (addr == REG_DLEN) begin
      dlen_q = data[DLEN_W-1:0];
      expected = DATA_W'(dlen_q);
      delay_ptr = '0;
      foreach (delay_mem[i]) delay_mem[i] = '0;
    end
    @(posedge clk);
    if (prdata !== expected) begin
      $error("prdata: expected %0d, actual %0d", expected, prdata);
      fail_count++;
    end
  endtask

  function automatic logic signed [SRC_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2:       return SRC_W'($urandom_range(0, 64)) - 16'sd32;
      default: return SRC_W'($urandom);
    endcase
  endfunction

  task automatic send_neuron(input int n_links);
    for (int i = 0; i < n_links; i++) send_link(pick_sample(), pick_sample(), i == n_links - 1);
  endtask

  task automatic test_softsign_extremes();
    send_link(Q_MAX, Q_MAX, 1'b1);
    send_link(Q_MIN, Q_MIN, 1'b1);
    send_link(Q_MIN, Q_MAX, 1'b1);
    send_link(16'sd0, 16'sd0, 1'b1);
    send_link(16'sd1, 16'sd1, 1'b1);
    send_link(-16'sd1, 16'sd1, 1'b1);
    send_link(Q_MAX, Q_MAX, 1'b0);
    send_link(Q_MAX, Q_MAX, 1'b1);
  endtask

  task automatic test_linear_kind();
    write_register(REG_KIND, DATA_W'(KIND_LINEAR));
    repeat (2) send_link(Q_MIN, Q_MIN, 1'b0);
    send_link(Q_MIN, Q_MIN, 1'b1);
    repeat (2) send_link(Q_MIN, Q_MAX, 1'b0);
    send_link(Q_MIN, Q_MAX, 1'b1);
    send_link(16'sd1, -16'sd1, 1'b1);
  endtask

  task automatic test_spare_kind();
    write_register(REG_KIND, DATA_W'(KIND_SPARE));
    send_link(16'sd12345, -16'sd777, 1'b1);
    send_link(Q_MIN, Q_MIN, 1'b0);
    send_link(Q_MIN, Q_MIN, 1'b1);
  endtask

  task automatic test_delayed_kind();
    write_register(REG_KIND, DATA_W'(KIND_DELAYED));
    send_link(16'sd4096, 16'sd4096, 1'b1);
    send_link(-16'sd300, 16'sd200, 1'b1);
    write_register(REG_DLEN, 32'd2);
    for (int i = 1; i <= 4; i++) send_link(SRC_W'(i * 1000), 16'sd4096, 1'b1);
    write_register(REG_KIND, DATA_W'(KIND_LINEAR));
    send_link(16'sd7777, -16'sd4096, 1'b1);
    write_register(REG_KIND, DATA_W'(KIND_DELAYED));
    send_link(Q_MAX, Q_MIN, 1'b1);
    send_link(Q_MIN, Q_MIN, 1'b1);
  endtask

  task automatic test_accumulator_saturation();
    write_register(REG_KIND, DATA_W'(KIND_SOFTSIGN));
    repeat (515) send_link(Q_MIN, Q_MIN, 1'b0);
    repeat (2) send_link(Q_MIN, Q_MAX, 1'b0);
    send_link(Q_MIN, Q_MAX, 1'b1);
    hold_for_results();
    repeat (515) send_link(Q_MIN, Q_MAX, 1'b0);
    repeat (2) send_link(Q_MIN, Q_MIN, 1'b0);
    send_link(Q_MIN, Q_MIN, 1'b1);
  endtask

  task automatic test_deep_delay();
    write_register(REG_KIND, DATA_W'(KIND_DELAYED));
    write_register(REG_DLEN, 32'd127);
    repeat (70) send_neuron(1);
  endtask

  task automatic test_random_streams();
    int stop_at;
    int lag;
    stop_at = links_sent + RANDOM_LINKS;
    while (links_sent < stop_at) begin
      if (links_sent > stop_at - RANDOM_LINKS / 6) idle_en = 1'b0;
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 7))
          0:       lag = 0;
          1:       lag = 1;
          2:       lag = 63;
          3:       lag = DELAY_DEPTH;
          4:       lag = 65;
          5:       lag = 127;
          default: lag = $urandom_range(0, 127);
        endcase
        write_register(REG_DLEN, DATA_W'(lag));
      end
      write_register(REG_KIND, DATA_W'($urandom_range(0, 3)));
      repeat ($urandom_range(3, 8)) begin
        if ($urandom_range(0, 15) == 0) hold_for_results();
        send_neuron(($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6));
      end
    end
    release_links();
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result_value: expected none, actual %0d", result_value);
        fail_count++;
      end else begin
        if (result_value !== pending_results[0]) begin
          $error("result_value: expected %0d, actual %0d", pending_results[0], result_value);
          fail_count++;
        end
        void'(pending_results.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    reset_predictor();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_softsign_extremes();
    test_linear_kind();
    test_spare_kind();
    test_delayed_kind();
    test_accumulator_saturation();
    test_deep_delay();
    test_random_streams();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/nmss_pkg.sv
rtl/core/neuron_mac_softsign.sv
rtl/core/nmss_check.sv
bench/tb_neuron_mac_softsign.sv
